/* sv/hprt_pkg.sv */
// Package for the heartbeat peak and rate tracker.
// Holds field widths, rate constants, register indexes and the controller/datapath structs.
// No dependencies.
package hprt_pkg;

    localparam int SAMPLE_W = 32;
    localparam int TIME_W   = 32;
    localparam int GAP_W    = 14;
    localparam int BPM_W    = 10;
    localparam int SUM_W    = 26;
    localparam int COUNT_W  = 16;
    localparam int QUOT_W   = 16;
    localparam int STEP_W   = 5;
    localparam int CFG_IDX_W = 1;

    localparam logic [QUOT_W-1:0]  RATE_NUM     = 16'd60000;
    localparam logic [BPM_W-1:0]   RATE_MAX     = 10'd599;
    localparam logic [COUNT_W-1:0] COUNT_MAX    = 16'hFFFF;
    localparam logic [GAP_W-1:0]   MIN_GAP_RST  = 14'd300;
    localparam logic [GAP_W-1:0]   MAX_GAP_RST  = 14'd2000;

    // Iteration counts of the shared divider for each of its two jobs.
    localparam logic [STEP_W-1:0] RATE_STEPS = 5'd16;
    localparam logic [STEP_W-1:0] AVG_STEPS  = 5'd26;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_GAP = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_GAP = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_in;
        logic eval;
        logic div_rate;
        logic div_avg;
        logic store_rate;
        logic accum;
        logic store_avg;
        logic load_out;
    } hprt_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic rise;
        logic fall;
        logic window;
        logic count_full;
        logic div_done;
    } hprt_status_t;

endpackage

/* sv/hprt_div.sv */
// Restoring divider shared by the rate and average computations, one quotient bit a cycle.
// Depends on hprt_pkg.
module hprt_div
    import hprt_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [SUM_W-1:0]    dividend,
    input  logic [COUNT_W-1:0]  divisor,
    input  logic [STEP_W-1:0]   steps,
    output logic                done,
    output logic [SUM_W-1:0]    quotient
);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [STEP_W-1:0]   cnt_reg, cnt_next;
    logic [COUNT_W-1:0]  rem_reg, rem_next;
    logic [COUNT_W-1:0]  dvs_reg, dvs_next;
    logic [SUM_W-1:0]    q_reg, q_next;
    logic [COUNT_W:0]    rem_shift;
    logic [COUNT_W:0]    rem_diff;
    logic                ge;

    // One trial subtraction of the divisor from the shifted remainder.
    assign rem_shift = {rem_reg, q_reg[SUM_W-1]};
    assign rem_diff  = rem_shift - {1'b0, dvs_reg};
    assign ge        = (rem_shift >= {1'b0, dvs_reg});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        q_next    = q_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = steps;
            rem_next  = '0;
            dvs_next  = divisor;
            q_next    = dividend;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? rem_diff[COUNT_W-1:0] : rem_shift[COUNT_W-1:0];
            q_next   = {q_reg[SUM_W-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == {{(STEP_W-1){1'b0}}, 1'b1})
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state of the iteration.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Remainder, divisor and quotient shift register.
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        q_reg   <= q_next;
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

/* sv/hprt_datapath.sv */
// Datapath: peak flag, beat timing, rate and average state, configuration and output registers.
// Depends on hprt_pkg and hprt_div.
module hprt_datapath
    import hprt_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  hprt_cmd_t               cmd,
    output hprt_status_t            status,
    input  logic signed [SAMPLE_W-1:0] sample,
    input  logic [TIME_W-1:0]       time_ms,
    input  logic                    cfg_we,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [GAP_W-1:0]        cfg_data,
    output logic                    beat_seen,
    output logic [BPM_W-1:0]        rate_bpm,
    output logic [BPM_W-1:0]        average_bpm,
    output logic                    in_peak
);

    logic [GAP_W-1:0]            min_gap_reg, max_gap_reg;
    logic signed [SAMPLE_W-1:0]  smp_reg;
    logic [TIME_W-1:0]           tim_reg;
    logic signed [SAMPLE_W-1:0]  prev_reg;
    logic                        flag_reg;
    logic [TIME_W-1:0]           last_beat_reg;
    logic [BPM_W-1:0]            rate_reg;
    logic [SUM_W-1:0]            sum_reg;
    logic [COUNT_W-1:0]          count_reg;
    logic [BPM_W-1:0]            avg_reg;
    logic                        beat_reg;
    logic                        out_beat_reg;
    logic [BPM_W-1:0]            out_rate_reg;
    logic [BPM_W-1:0]            out_avg_reg;
    logic                        out_peak_reg;

    logic [TIME_W-1:0]           gap;
    logic                        div_start;
    logic [SUM_W-1:0]            div_dividend;
    logic [COUNT_W-1:0]          div_divisor;
    logic [STEP_W-1:0]           div_steps;
    logic                        div_done;
    logic [SUM_W-1:0]            div_quot;
    logic [QUOT_W-1:0]           rate_quot;
    logic [BPM_W-1:0]            rate_sat;

    // Interval since the last beat, modulo 2^32, and the window test.
    assign gap = tim_reg - last_beat_reg;

    assign status.rise       = (smp_reg > prev_reg) && !flag_reg;
    assign status.fall       = (smp_reg < prev_reg) && flag_reg;
    assign status.window     = (gap > {{(TIME_W-GAP_W){1'b0}}, min_gap_reg})
                            && (gap < {{(TIME_W-GAP_W){1'b0}}, max_gap_reg});
    assign status.count_full = (count_reg == COUNT_MAX);
    assign status.div_done   = div_done;

    // Divider operands: 60000 placed in the top bits for the rate, sum over count for the average.
    assign div_start    = cmd.div_rate || cmd.div_avg;
    assign div_dividend = cmd.div_rate ? {RATE_NUM, {(SUM_W-QUOT_W){1'b0}}} : sum_reg;
    assign div_divisor  = cmd.div_rate ? gap[COUNT_W-1:0] : count_reg;
    assign div_steps    = cmd.div_rate ? RATE_STEPS : AVG_STEPS;

    hprt_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .steps    (div_steps),
        .done     (div_done),
        .quotient (div_quot)
    );

    // Rates above the ceiling are clamped.
    assign rate_quot = div_quot[QUOT_W-1:0];
    assign rate_sat  = (rate_quot > {{(QUOT_W-BPM_W){1'b0}}, RATE_MAX})
                     ? RATE_MAX : rate_quot[BPM_W-1:0];

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_gap_reg <= MIN_GAP_RST;
            max_gap_reg <= MAX_GAP_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_MIN_GAP: min_gap_reg <= cfg_data;
                CFG_MAX_GAP: max_gap_reg <= cfg_data;
            endcase
        end
    end

    // Captured input item.
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            smp_reg <= sample;
            tim_reg <= time_ms;
        end
    end

    // Tracker state: peak flag, beat time, rate, sum, count and average.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg      <= '0;
            flag_reg      <= 1'b0;
            last_beat_reg <= '0;
            rate_reg      <= '0;
            sum_reg       <= '0;
            count_reg     <= '0;
            avg_reg       <= '0;
            beat_reg      <= 1'b0;
        end
        else
        begin
            if (cmd.load_in)
            begin
                beat_reg <= 1'b0;
            end
            if (cmd.eval)
            begin
                prev_reg <= smp_reg;
                if (status.rise)
                begin
                    flag_reg <= 1'b1;
                end
                else if (status.fall)
                begin
                    flag_reg      <= 1'b0;
                    last_beat_reg <= tim_reg;
                end
            end
            if (cmd.store_rate)
            begin
                rate_reg <= rate_sat;
                beat_reg <= 1'b1;
            end
            if (cmd.accum)
            begin
                sum_reg   <= sum_reg + {{(SUM_W-BPM_W){1'b0}}, rate_reg};
                count_reg <= count_reg + 1'b1;
            end
            if (cmd.store_avg)
            begin
                avg_reg <= div_quot[BPM_W-1:0];
            end
        end
    end

    // Result register, loaded once the item is finished.
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_beat_reg <= beat_reg;
            out_rate_reg <= rate_reg;
            out_avg_reg  <= avg_reg;
            out_peak_reg <= flag_reg;
        end
    end

    assign beat_seen   = out_beat_reg;
    assign rate_bpm    = out_rate_reg;
    assign average_bpm = out_avg_reg;
    assign in_peak     = out_peak_reg;

endmodule

/* sv/hprt_ctrl.sv */
// Controller state machine: sequences evaluation, the two divisions and the result handoff.
// Depends on hprt_pkg.
module hprt_ctrl
    import hprt_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_stall,
    output logic         out_valid,
    input  logic         out_stall,
    input  hprt_status_t status,
    output hprt_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_RATE_WAIT,
        ST_ACCUM,
        ST_AVG_GO,
        ST_AVG_WAIT,
        ST_OUT
    } state_t;

    state_t state_reg, state_next;
    logic   in_stall_reg, in_stall_next;
    logic   out_valid_reg, out_valid_next;

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                cmd.eval = 1'b1;
                if (status.fall && status.window)
                begin
                    cmd.div_rate = 1'b1;
                    state_next   = ST_RATE_WAIT;
                end
                else
                begin
                    state_next = ST_OUT;
                end
            end
            ST_RATE_WAIT:
            begin
                if (status.div_done)
                begin
                    cmd.store_rate = 1'b1;
                    state_next     = status.count_full ? ST_OUT : ST_ACCUM;
                end
            end
            ST_ACCUM:
            begin
                cmd.accum  = 1'b1;
                state_next = ST_AVG_GO;
            end
            ST_AVG_GO:
            begin
                cmd.div_avg = 1'b1;
                state_next  = ST_AVG_WAIT;
            end
            ST_AVG_WAIT:
            begin
                if (status.div_done)
                begin
                    cmd.store_avg = 1'b1;
                    state_next    = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Handshake outputs: a new item is taken only in idle; the result holds until taken.
    always_comb
    begin
        in_stall_next = (state_next != ST_IDLE);
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            in_stall_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            in_stall_reg  <= in_stall_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = in_stall_reg;
    assign out_valid = out_valid_reg;

endmodule

/* sv/heartbeat_peak_rate_tracker_core.sv */
// Heartbeat peak and rate tracker, top level.
// A sample that marks no accepted beat goes from evaluation straight to the result registers;
// an accepted beat runs the rate and then the average division; at full count only the rate.
// One item at a time; the next item is taken the cycle after the result is loaded.
// Reset (asynchronous, active low) clears all tracker state and sets the gap limits to 300/2000.
// Depends on hprt_pkg, hprt_ctrl, hprt_datapath and hprt_div.
module heartbeat_peak_rate_tracker_core
    import hprt_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic signed [SAMPLE_W-1:0] sample,
    input  logic [TIME_W-1:0]          time_ms,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic                       beat_seen,
    output logic [BPM_W-1:0]           rate_bpm,
    output logic [BPM_W-1:0]           average_bpm,
    output logic                       in_peak,
    input  logic                       cfg_we,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [GAP_W-1:0]           cfg_data
);

    hprt_cmd_t    cmd;
    hprt_status_t status;

    // Sequencing of one item.
    hprt_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    // State, arithmetic and result registers.
    hprt_datapath u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .sample      (sample),
        .time_ms     (time_ms),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .beat_seen   (beat_seen),
        .rate_bpm    (rate_bpm),
        .average_bpm (average_bpm),
        .in_peak     (in_peak)
    );

endmodule

/* sv/hprt_checker.sv */
// Port-level checks of the heartbeat tracker, bound to the top level.
// Depends on hprt_pkg and heartbeat_peak_rate_tracker_core.
module hprt_checker
    import hprt_pkg::*;
(
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_stall,
    input logic                       out_valid,
    input logic                       out_stall,
    input logic                       beat_seen,
    input logic [BPM_W-1:0]           rate_bpm,
    input logic [BPM_W-1:0]           average_bpm,
    input logic                       in_peak
);

    // An accepted item keeps the input side busy in the following cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input taken twice in a row");

    // A beat always ends a peak, so the flag is clear with it.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && beat_seen) |-> !in_peak)
        else $error("beat reported while peak flag set");

    // Reported rate never exceeds the ceiling.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (rate_bpm <= RATE_MAX))
        else $error("rate above ceiling");

    // A stalled result stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> out_valid)
        else $error("result dropped while stalled");

    // A stalled result does not change.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> ($stable(beat_seen) && $stable(rate_bpm)
                                      && $stable(average_bpm) && $stable(in_peak)))
        else $error("result changed while stalled");

endmodule

bind heartbeat_peak_rate_tracker_core hprt_checker u_hprt_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .beat_seen   (beat_seen),
    .rate_bpm    (rate_bpm),
    .average_bpm (average_bpm),
    .in_peak     (in_peak)
);

/* dv/tb_heartbeat_peak_rate_tracker_core.sv */
// Testbench for heartbeat_peak_rate_tracker_core: sends sample items with timestamps and checks
// every result item against a built-in beat and rate predictor held in a small scoreboard class.
// Depends on hprt_pkg and the heartbeat_peak_rate_tracker_core RTL.
`timescale 1ns / 1ps

import hprt_pkg::*;

// One result item as the block presents it.
typedef struct packed {
    logic             beat;
    logic [BPM_W-1:0] rate;
    logic [BPM_W-1:0] average;
    logic             peak;
} tracker_result_t;

// Tracks the beat detector state and holds the result items still to come.
class tracker_scoreboard;
    localparam int MAX_REPORTS = 10;

    logic [GAP_W-1:0]           min_gap;
    logic [GAP_W-1:0]           max_gap;
    logic signed [SAMPLE_W-1:0] prev_sample;
    bit                         peak;
    logic [TIME_W-1:0]          last_beat;
    logic [BPM_W-1:0]           last_rate;
    logic [SUM_W-1:0]           rate_sum;
    logic [COUNT_W-1:0]         rate_count;
    logic [BPM_W-1:0]           rate_avg;
    tracker_result_t            expected_q[$];
    int unsigned                mismatches;

    function new();
        min_gap     = MIN_GAP_RST;
        max_gap     = MAX_GAP_RST;
        prev_sample = '0;
        peak        = 1'b0;
        last_beat   = '0;
        last_rate   = '0;
        rate_sum    = '0;
        rate_count  = '0;
        rate_avg    = '0;
        mismatches  = 0;
    endfunction

    function void write_gap(logic [CFG_IDX_W-1:0] idx, logic [GAP_W-1:0] value);
        if (idx == CFG_MIN_GAP)
            min_gap = value;
        else if (idx == CFG_MAX_GAP)
            max_gap = value;
    endfunction

    function int pending();
        return expected_q.size();
    endfunction

    function void note_mismatch(string what);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("%0t: mismatch: %s", $time, what);
    endfunction

    // Applies one accepted sample item and queues the result item it causes.
    function void note_sample(logic signed [SAMPLE_W-1:0] s, logic [TIME_W-1:0] t);
        tracker_result_t   res;
        logic [TIME_W-1:0] gap;
        int unsigned       bpm;
        res.beat = 1'b0;
        if (s > prev_sample && !peak) begin
            peak = 1'b1;
        end
        else if (s < prev_sample && peak) begin
            // A falling sample ends the peak; the interval wraps modulo 2^32.
            peak      = 1'b0;
            gap       = t - last_beat;
            last_beat = t;
            if (gap > min_gap && gap < max_gap) begin
                bpm = RATE_NUM / gap;
                if (bpm > RATE_MAX)
                    bpm = 32'(RATE_MAX);
                last_rate = BPM_W'(bpm);
                res.beat  = 1'b1;
                // The sum and count freeze once the count is full.
                if (rate_count != COUNT_MAX) begin
                    rate_sum   = SUM_W'(rate_sum + bpm);
                    rate_count = rate_count + 1'b1;
                    rate_avg   = BPM_W'(rate_sum / rate_count);
                end
            end
        end
        prev_sample = s;
        res.rate    = last_rate;
        res.average = rate_avg;
        res.peak    = peak;
        expected_q.push_back(res);
    endfunction

    // Compares one result item with the oldest expected one.
    function void check_result(tracker_result_t got);
        tracker_result_t want;
        if (expected_q.size() == 0) begin
            note_mismatch($sformatf("result with none expected: beat %0d rate %0d avg %0d peak %0d",
                                    got.beat, got.rate, got.average, got.peak));
            return;
        end
        want = expected_q.pop_front();
        if (got.beat !== want.beat)
            note_mismatch($sformatf("beat_seen expected %0d, got %0d", want.beat, got.beat));
        if (got.rate !== want.rate)
            note_mismatch($sformatf("rate_bpm expected %0d, got %0d", want.rate, got.rate));
        if (got.average !== want.average)
            note_mismatch($sformatf("average_bpm expected %0d, got %0d",
                                    want.average, got.average));
        if (got.peak !== want.peak)
            note_mismatch($sformatf("in_peak expected %0d, got %0d", want.peak, got.peak));
    endfunction
endclass

module tb_heartbeat_peak_rate_tracker_core;

    localparam int HOLD_CYCLES    = 400;
    localparam int DRAIN_CYCLES   = 64;
    localparam int WATCHDOG_LIMIT = 5000;

    logic                       clk;
    logic                       rst_n;
    logic                       in_valid;
    logic                       in_stall;
    logic signed [SAMPLE_W-1:0] sample;
    logic [TIME_W-1:0]          time_ms;
    logic                       out_valid;
    logic                       out_stall;
    logic                       beat_seen;
    logic [BPM_W-1:0]           rate_bpm;
    logic [BPM_W-1:0]           average_bpm;
    logic                       in_peak;
    logic                       cfg_we;
    logic [CFG_IDX_W-1:0]       cfg_index;
    logic [GAP_W-1:0]           cfg_data;

    tracker_scoreboard sb;
    int unsigned       send_idle_pct;
    int unsigned       stall_pct;
    bit                hold_req;

    heartbeat_peak_rate_tracker_core DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .sample      (sample),
        .time_ms     (time_ms),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .beat_seen   (beat_seen),
        .rate_bpm    (rate_bpm),
        .average_bpm (average_bpm),
        .in_peak     (in_peak),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    // 8 ns clock.
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Receiver: random stalls, or one long hold-off when asked for.
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
            end
            out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    // Result item monitor.
    always @(posedge clk)
    begin : result_monitor
        tracker_result_t got;
        if (rst_n && out_valid && !out_stall)
        begin
            got.beat    = beat_seen;
            got.rate    = rate_bpm;
            got.average = average_bpm;
            got.peak    = in_peak;
            sb.check_result(got);
        end
    end

    // Ends the run if no item moves on either side for too long.
    initial
    begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
        $display("tb_heartbeat_peak_rate_tracker_core: FAIL");
        $finish;
    end

    // Offers one item from a falling edge and returns at the falling edge after it is taken.
    task automatic send_item(input logic signed [SAMPLE_W-1:0] s, input logic [TIME_W-1:0] t);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        sample   <= s;
        time_ms  <= t;
        forever
        begin
            @(posedge clk);
            if (!in_stall)
                break;
        end
        sb.note_sample(s, t);
        @(negedge clk);
    endtask

    // Stops offering and waits until every expected result item has come.
    task automatic wait_results();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (sb.pending() != 0);
    endtask

    // Writes both gap limits; the block must be idle.
    task automatic write_gaps(input logic [GAP_W-1:0] lo, input logic [GAP_W-1:0] hi);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_MIN_GAP;
        cfg_data  <= lo;
        @(negedge clk);
        cfg_index <= CFG_MAX_GAP;
        cfg_data  <= hi;
        @(negedge clk);
        cfg_we    <= 1'b0;
        sb.write_gap(CFG_MIN_GAP, lo);
        sb.write_gap(CFG_MAX_GAP, hi);
    endtask

    // Moves a sample up or down by a random step that stays in range.
    function automatic logic signed [SAMPLE_W-1:0] step_sample(
        input logic signed [SAMPLE_W-1:0] from, input bit up);
        longint base;
        longint room;
        longint delta;
        base = longint'(from);
        room = up ? (64'sd2147483647 - base) : (base + 64'sd2147483648);
        if (room == 0)
            return from;
        if ($urandom_range(0, 1))
            delta = longint'($urandom_range(1, 1000));
        else
            delta = longint'($urandom) + 1;
        if (delta > room)
            delta = ((delta - 1) % room) + 1;
        return up ? SAMPLE_W'(base + delta) : SAMPLE_W'(base - delta);
    endfunction

    // Beat interval aimed at the window edges, inside it, far below and far beyond it.
    function automatic logic [TIME_W-1:0] pick_gap(input int unsigned lo, input int unsigned hi);
        case ($urandom_range(0, 9))
            0: return $urandom_range(1, 100);
            1: return lo;
            2: return lo + 1;
            3: return hi - 1;
            4: return hi;
            5: return $urandom;
            default:
                if (hi > lo + 1)
                    return $urandom_range(lo + 1, hi - 1);
                else
                    return $urandom_range(0, 16383);
        endcase
    endfunction

    // One phase: new gap limits, an idling mode, then mostly rise/fall pulse trains with noise.
    task automatic run_phase(input int unsigned lo, input int unsigned hi,
                             input int unsigned snd, input int unsigned rcv,
                             input int unsigned items, input bit hold, input bit pause);
        logic signed [SAMPLE_W-1:0] s;
        logic [TIME_W-1:0]          t;
        write_gaps(GAP_W'(lo), GAP_W'(hi));
        send_idle_pct = snd;
        stall_pct     = rcv;
        for (int unsigned n = 0; n < items; n++)
        begin
            if (n == items / 2)
            begin
                if (hold)
                    hold_req = 1'b1;
                if (pause)
                    wait_results();
            end
            case ($urandom_range(0, 19))
                0, 1:
                begin
                    s = $urandom;
                    t = $urandom;
                end
                2:
                begin
                    s = sb.prev_sample;
                    t = sb.last_beat + $urandom_range(1, 200);
                end
                default:
                begin
                    if (!sb.peak || $urandom_range(0, 99) < 15)
                    begin
                        s = step_sample(sb.prev_sample, 1'b1);
                        t = sb.last_beat + $urandom_range(1, 200);
                    end
                    else
                    begin
                        s = step_sample(sb.prev_sample, 1'b0);
                        t = sb.last_beat + pick_gap(lo, hi);
                    end
                end
            endcase
            send_item(s, t);
        end
        wait_results();
    endtask

    // Main sequence.
    initial
    begin
        sb            = new();
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        sample        = '0;
        time_ms       = '0;
        cfg_we        = 1'b0;
        cfg_index     = CFG_MIN_GAP;
        cfg_data      = '0;
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_req      = 1'b0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed items under the reset gap limits.
        send_item(32'sd0, 32'd0);                          // equal to the reset sample
        send_item(32'sd100, 32'd5);                        // rise sets the flag
        send_item(32'sd200, 32'd6);                        // rise while the flag is set
        send_item(32'sd200, 32'd7);                        // equal samples
        send_item(32'sd50, 32'd500);                       // first beat, timed from zero
        send_item(32'sh7FFF_FFFF, 32'd600);                // most positive sample
        send_item(32'sh8000_0000, 32'd700);                // fall to most negative, too soon
        send_item(32'sh8000_0000, 32'd800);                // equal at most negative
        send_item(-32'sd5, 32'd900);
        send_item(-32'sd6, 32'd1700);                      // accepted beat
        send_item(32'sd10, 32'd1800);
        send_item(32'sd9, 32'd2001);                       // just above the lower limit
        send_item(32'sd20, 32'd2100);
        send_item(32'sd19, 32'd4000);                      // just below the upper limit
        send_item(32'sd30, 32'd4100);
        send_item(32'sd29, 32'd4300);                      // equal to the lower limit
        send_item(32'sd40, 32'd4400);
        send_item(32'sd39, 32'd6300);                      // equal to the upper limit
        send_item(32'sd50, 32'hFFFF_FD00);
        send_item(32'sd49, 32'hFFFF_FE00);                 // far too late, rejected
        send_item(32'sd60, 32'hFFFF_FFFF);                 // largest timestamp
        send_item(32'sd59, 32'h0000_0100);                 // interval across the wrap
        wait_results();

        // Random phases over several gap windows and idling modes.
        run_phase(100, 10000, 0, 0, 200, 1'b0, 1'b0);
        run_phase(0, 16383, 54, 0, 220, 1'b0, 1'b0);
        run_phase(500, 501, 0, 54, 150, 1'b1, 1'b0);
        run_phase(16383, 0, 29, 29, 100, 1'b0, 1'b0);
        run_phase(50, 700, 29, 29, 220, 1'b0, 1'b1);
        run_phase(1000, 1003, 0, 0, 150, 1'b0, 1'b0);
        run_phase(10000, 16383, 54, 0, 200, 1'b0, 1'b0);
        run_phase(1, 150, 0, 54, 220, 1'b0, 1'b0);
        run_phase(300, 2000, 29, 29, 240, 1'b0, 1'b0);

        repeat (DRAIN_CYCLES) @(negedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("tb_heartbeat_peak_rate_tracker_core: PASS");
        else
            $display("tb_heartbeat_peak_rate_tracker_core: FAIL");
        $finish;
    end

endmodule
